[hdl/phong_point_light_shader_defines.svh]
// assertion helpers used by the shader queue
// both expect signals named clk and rst_n in the enclosing scope
`ifndef PHONG_POINT_LIGHT_SHADER_DEFINES_SVH
`define PHONG_POINT_LIGHT_SHADER_DEFINES_SVH

// same-cycle implication
`define PPLSH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPLSH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pplsh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplsh_pkg
// shared constants, item type and fixed-point helpers of the phong shader
// ----------------------------------------------------------------------------
package pplsh_pkg;

    localparam int VEC_FRAC    = 14;
    localparam int DOT_SHIFT   = 2 * VEC_FRAC - 15;
    localparam int R_SHIFT     = 2 * VEC_FRAC;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [15:0] Q15_ONE = 16'h8000;
    localparam logic [15:0] Q15_MAX = 16'hFFFF;

    // item handed from the geometry front to the colour back
    typedef struct packed {
        logic [47:0] diffuse_coef;
        logic [47:0] specular_coef;
        logic [47:0] light_intensity;
        logic [7:0]  shininess;
        logic [15:0] nl15;
        logic [15:0] rv15;
    } shade_item_t;

    // q1.15 multiply, round half up, saturate
    function automatic logic [15:0] q15_mul(input logic [15:0] a, input logic [15:0] b);
        logic [32:0] p;
        p = 33'(a) * 33'(b) + 33'h4000;
        if (p[32:15] > 18'(Q15_MAX))
            return Q15_MAX;
        return p[30:15];
    endfunction

    // clamp dot product at zero, round to q1.15, saturate
    function automatic logic [15:0] dot_to_q15(input logic signed [40:0] d);
        logic [41:0] t;
        logic [41:0] r;
        t = 42'(unsigned'(d)) + (42'd1 << (DOT_SHIFT - 1));
        r = t >> DOT_SHIFT;
        if (d <= 41'sd0)
            return 16'd0;
        if (r > 42'(Q15_MAX))
            return Q15_MAX;
        return r[15:0];
    endfunction

endpackage

[hdl/pplsh_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplsh_in_if
// input channel of the shader: vectors, colours, exponent, intensity
// ----------------------------------------------------------------------------
interface pplsh_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] light_dir;
    logic [47:0] surface_normal;
    logic [47:0] view_dir;
    logic [47:0] diffuse_coef;
    logic [47:0] specular_coef;
    logic [7:0]  shininess;
    logic [47:0] light_intensity;

    modport source (output valid, light_dir, surface_normal, view_dir, diffuse_coef,
                    specular_coef, shininess, light_intensity, input ready);
    modport sink   (input valid, light_dir, surface_normal, view_dir, diffuse_coef,
                    specular_coef, shininess, light_intensity, output ready);
endinterface

[hdl/pplsh_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplsh_out_if
// result channel of the shader: one rgb colour per beat
// ----------------------------------------------------------------------------
interface pplsh_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

[hdl/pplsh_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplsh_front
// geometry pipeline: n.l, reflected vector, r.v, both clamped to q1.15
// ----------------------------------------------------------------------------
module pplsh_front (
    input  logic                   clk,
    input  logic                   rst_n,
    pplsh_in_if.sink               in_ch,
    output logic                   item_valid,
    output pplsh_pkg::shade_item_t item,
    input  logic                   item_ready
);

    typedef struct packed {
        logic [47:0] kd;
        logic [47:0] kr;
        logic [47:0] li;
        logic [7:0]  shin;
    } color_t;

    logic [5:0] v_reg;
    logic       en;

    logic signed [15:0] n_in [3];
    logic signed [15:0] l_in [3];
    logic signed [15:0] w_in [3];
    color_t             c_in;

    // stage 1: component products of n.l
    logic signed [15:0] n1_reg [3];
    logic signed [15:0] l1_reg [3];
    logic signed [15:0] w1_reg [3];
    logic signed [31:0] p1_reg [3];
    color_t             c1_reg;
    // stage 2: n.l
    logic signed [15:0] n2_reg [3];
    logic signed [15:0] l2_reg [3];
    logic signed [15:0] w2_reg [3];
    logic signed [32:0] nl2_reg;
    logic [15:0]        nl15_2_reg;
    color_t             c2_reg;
    logic signed [32:0] nl2_next;
    // stage 3: (n.l) * n_i
    logic signed [15:0] l3_reg [3];
    logic signed [15:0] w3_reg [3];
    logic signed [48:0] t3_reg [3];
    logic [15:0]        nl15_3_reg;
    color_t             c3_reg;
    // stage 4: reflected vector
    logic signed [15:0] w4_reg [3];
    logic signed [22:0] r4_reg [3];
    logic [15:0]        nl15_4_reg;
    color_t             c4_reg;
    logic signed [22:0] r4_next [3];
    // stage 5: component products of r.v
    logic signed [40:0] p5_reg [3];
    logic [15:0]        nl15_5_reg;
    color_t             c5_reg;
    // stage 6: r.v and the item for the queue
    pplsh_pkg::shade_item_t item_reg;
    logic signed [40:0]     rv_next;

    assign en = !v_reg[5] || item_ready;
    assign in_ch.ready = en;
    assign item_valid = v_reg[5];
    assign item = item_reg;

    // unpack input vectors and colours
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_in[i] = in_ch.surface_normal[16*i +: 16];
            l_in[i] = in_ch.light_dir[16*i +: 16];
            w_in[i] = in_ch.view_dir[16*i +: 16];
        end
        c_in.kd   = in_ch.diffuse_coef;
        c_in.kr   = in_ch.specular_coef;
        c_in.li   = in_ch.light_intensity;
        c_in.shin = in_ch.shininess;
    end

    // dot sums and reflection rounding
    always_comb
    begin
        logic [48:0] mag;
        logic [48:0] q;
        logic signed [22:0] qs;
        nl2_next = 33'(p1_reg[0]) + 33'(p1_reg[1]) + 33'(p1_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            mag = t3_reg[i][48] ? 49'(-t3_reg[i]) : 49'(t3_reg[i]);
            q   = (mag + (49'd1 << (pplsh_pkg::R_SHIFT - 2))) >> (pplsh_pkg::R_SHIFT - 1);
            qs  = 23'(q);
            r4_next[i] = (t3_reg[i][48] ? -qs : qs) - 23'(l3_reg[i]);
        end
        rv_next = p5_reg[0] + p5_reg[1] + p5_reg[2];
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], in_ch.valid};
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n1_reg[i] <= n_in[i];
                l1_reg[i] <= l_in[i];
                w1_reg[i] <= w_in[i];
                p1_reg[i] <= 32'(n_in[i]) * 32'(l_in[i]);
                n2_reg[i] <= n1_reg[i];
                l2_reg[i] <= l1_reg[i];
                w2_reg[i] <= w1_reg[i];
                l3_reg[i] <= l2_reg[i];
                w3_reg[i] <= w2_reg[i];
                t3_reg[i] <= 49'(nl2_reg) * 49'(n2_reg[i]);
                w4_reg[i] <= w3_reg[i];
                r4_reg[i] <= r4_next[i];
                p5_reg[i] <= 41'(r4_reg[i]) * 41'(w4_reg[i]);
            end
            c1_reg     <= c_in;
            nl2_reg    <= nl2_next;
            nl15_2_reg <= pplsh_pkg::dot_to_q15(41'(nl2_next));
            c2_reg     <= c1_reg;
            nl15_3_reg <= nl15_2_reg;
            c3_reg     <= c2_reg;
            nl15_4_reg <= nl15_3_reg;
            c4_reg     <= c3_reg;
            nl15_5_reg <= nl15_4_reg;
            c5_reg     <= c4_reg;
            item_reg.diffuse_coef    <= c5_reg.kd;
            item_reg.specular_coef   <= c5_reg.kr;
            item_reg.light_intensity <= c5_reg.li;
            item_reg.shininess       <= c5_reg.shin;
            item_reg.nl15            <= nl15_5_reg;
            item_reg.rv15            <= pplsh_pkg::dot_to_q15(rv_next);
        end
    end

endmodule

[hdl/pplsh_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplsh_queue
// small fifo that decouples the geometry front from the colour back
// ----------------------------------------------------------------------------
`include "phong_point_light_shader_defines.svh"

module pplsh_queue #(
    parameter int DEPTH = pplsh_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pplsh_pkg::shade_item_t push_data,
    output logic                   full,
    input  logic                   pop,
    output pplsh_pkg::shade_item_t pop_data,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pplsh_pkg::shade_item_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    `PPLSH_ASSERT_IMP(a_no_overflow, push, !full, "queue written while full")
    `PPLSH_ASSERT_IMP(a_no_underflow, pop, !empty, "queue read while empty")
    `PPLSH_ASSERT_NXT(a_count_up, push && !pop, count_reg == CNT_W'($past(count_reg) + 1'b1), "fill level did not rise")

endmodule

[hdl/pplsh_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pplsh_back
// colour pipeline: specular power by square and multiply, rgb mix, saturation
// ----------------------------------------------------------------------------
module pplsh_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  pplsh_pkg::shade_item_t q_data,
    output logic                   q_pop,
    pplsh_out_if.source            out_ch
);

    logic en;

    // power pipeline, a load stage then one exponent bit per stage
    logic                   pv_reg   [9];
    logic [15:0]            acc_reg  [9];
    logic [15:0]            base_reg [9];
    pplsh_pkg::shade_item_t it_reg   [9];

    // mix stages
    logic        v9_reg, v10_reg, v11_reg;
    logic [31:0] dp9_reg [3];
    logic [31:0] sp9_reg [3];
    logic [47:0] li9_reg, li10_reg;
    logic [32:0] sum10_reg [3];
    logic [48:0] pr11_reg [3];

    logic        out_valid_reg;
    logic [15:0] rgb_reg  [3];
    logic [15:0] rgb_next [3];

    assign en    = !out_valid_reg || out_ch.ready;
    assign q_pop = en && !q_empty;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.red   = rgb_reg[0];
    assign out_ch.green = rgb_reg[1];
    assign out_ch.blue  = rgb_reg[2];

    // final rounding and saturation
    always_comb
    begin
        logic [49:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c = (50'(pr11_reg[i]) + (50'd1 << 29)) >> 30;
            rgb_next[i] = (c > 50'(pplsh_pkg::Q15_MAX)) ? pplsh_pkg::Q15_MAX : c[15:0];
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                pv_reg[k] <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg[0] <= !q_empty;
            for (int k = 1; k < 9; k++)
                pv_reg[k] <= pv_reg[k-1];
            v9_reg        <= pv_reg[8];
            v10_reg       <= v9_reg;
            v11_reg       <= v10_reg;
            out_valid_reg <= v11_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0]  <= pplsh_pkg::Q15_ONE;
            base_reg[0] <= q_data.rv15;
            it_reg[0]   <= q_data;
            for (int k = 1; k < 9; k++)
            begin
                acc_reg[k]  <= it_reg[k-1].shininess[k-1]
                               ? pplsh_pkg::q15_mul(acc_reg[k-1], base_reg[k-1])
                               : acc_reg[k-1];
                base_reg[k] <= pplsh_pkg::q15_mul(base_reg[k-1], base_reg[k-1]);
                it_reg[k]   <= it_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                dp9_reg[i]   <= 32'(it_reg[8].diffuse_coef[16*i +: 16]) * 32'(it_reg[8].nl15);
                sp9_reg[i]   <= 32'(it_reg[8].specular_coef[16*i +: 16]) * 32'(acc_reg[8]);
                sum10_reg[i] <= 33'(dp9_reg[i]) + 33'(sp9_reg[i]);
                pr11_reg[i]  <= 49'(li10_reg[16*i +: 16]) * 49'(sum10_reg[i]);
                rgb_reg[i]   <= rgb_next[i];
            end
            li9_reg  <= it_reg[8].light_intensity;
            li10_reg <= li9_reg;
        end
    end

endmodule

[hdl/phong_point_light_shader.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phong_point_light_shader
// phong diffuse plus specular term of one point light, one pixel per beat
// ----------------------------------------------------------------------------
// in_ch carries the light, normal and view vectors (signed q1.14), diffuse
// and specular colours and light intensity (unsigned q1.15 rgb) and the
// integer shininess; out_ch carries one red, green, blue result per input.
// A beat moves when valid and ready are both high on a rising clk edge.
// One beat is taken per cycle while in_ch.ready is high; a result passes
// through six geometry stages, the queue, a load stage and eight power
// stages (one exponent bit each) and four mix and rounding stages.
// A small queue sits between the geometry front and colour back, so the
// front keeps taking beats while the output is stalled until that queue
// fills; in_ch.ready then drops. A stalled result holds on out_ch.
// rst_n clears all valid flags and the queue; no beat is in flight after it.
// ----------------------------------------------------------------------------
module phong_point_light_shader #(
    parameter int QUEUE_DEPTH = pplsh_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    pplsh_in_if.sink    in_ch,
    pplsh_out_if.source out_ch
);

    logic                   f_valid;
    pplsh_pkg::shade_item_t f_item;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    pplsh_pkg::shade_item_t q_data;

    // geometry front
    pplsh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item_valid (f_valid),
        .item       (f_item),
        .item_ready (!q_full)
    );

    // decoupling queue
    pplsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && !q_full),
        .push_data (f_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // colour back
    pplsh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

[bench/phong_point_light_shader_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phong_point_light_shader_tb
// self-checking bench of the phong point light shader
// ----------------------------------------------------------------------------
// A directed table of beats (reset defaults, extremes, saturation, zero
// exponent, back-facing light) is followed by random beats, mostly near-unit
// vectors with random colours. Each accepted beat is run through a local
// fixed-point shading model, the expected colour queued; each output beat is
// compared with the oldest, or a row's fixed one. Both sides idle at random.
// ----------------------------------------------------------------------------
module phong_point_light_shader_tb;

    typedef struct {
        logic [47:0] l, n, v, kd, ks, li;
        logic [7:0]  sh;
        logic        has_exp;
        logic [47:0] exp_rgb;
    } shade_row_t;

    typedef struct {
        logic [47:0] l, n, v, kd, ks, li;
        logic [7:0]  sh;
    } shade_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    pplsh_in_if  in_ch ();
    pplsh_out_if out_ch ();

    phong_point_light_shader DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic [47:0] expected_colors[$];
    logic [47:0] fixed_colors[$];
    logic        fixed_valid[$];
    int          mismatch_count = 0;
    bit          sink_pause_on = 1'b1;

    localparam int NUM_RANDOM = 800;

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // signed 16-bit component
    function automatic longint comp_s(input logic [47:0] v, input int i);
        logic signed [15:0] c;
        c = v[16*i +: 16];
        return longint'(c);
    endfunction

    function automatic longint q15_mult(input longint a, input longint b);
        longint r;
        r = (a * b + 16384) >>> 15;
        return (r > 65535) ? 65535 : r;
    endfunction

    function automatic longint dot_q15(input longint d);
        longint r;
        if (d <= 0)
            return 0;
        r = (d + (64'sd1 <<< (2 * pplsh_pkg::VEC_FRAC - 16))) >>> (2 * pplsh_pkg::VEC_FRAC - 15);
        return (r > 65535) ? 65535 : r;
    endfunction

    // expected rgb of one beat
    function automatic logic [47:0] shade_color(input shade_beat_t b);
        longint l[3], n[3], v[3];
        longint nl, rv, t, half, nl15, base, acc, sum, c;
        logic [47:0] res;
        nl = 0;
        rv = 0;
        half = 64'sd1 <<< (2 * pplsh_pkg::VEC_FRAC - 1);
        for (int i = 0; i < 3; i++)
        begin
            l[i] = comp_s(b.l, i);
            n[i] = comp_s(b.n, i);
            v[i] = comp_s(b.v, i);
            nl += n[i] * l[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            t = 2 * nl * n[i];
            if (t >= 0)
                t = (t + half) >>> (2 * pplsh_pkg::VEC_FRAC);
            else
                t = -((-t + half) >>> (2 * pplsh_pkg::VEC_FRAC));
            rv += (t - l[i]) * v[i];
        end
        nl15 = dot_q15(nl);
        base = dot_q15(rv);
        acc = 32768;
        for (int i = 0; i < 8; i++)
        begin
            if (b.sh[i])
                acc = q15_mult(acc, base);
            base = q15_mult(base, base);
        end
        for (int i = 0; i < 3; i++)
        begin
            sum = longint'(b.kd[16*i +: 16]) * nl15 + longint'(b.ks[16*i +: 16]) * acc;
            c = (longint'(b.li[16*i +: 16]) * sum + (64'sd1 <<< 29)) >>> 30;
            res[16*i +: 16] = (c > 65535) ? 16'hFFFF : 16'(c);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // random vector, mostly near unit length along an axis mix
    function automatic logic [47:0] rand_vec(input bit wild);
        logic [47:0] v;
        if (wild)
            return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
        for (int i = 0; i < 3; i++)
            v[16*i +: 16] = 16'($signed($urandom_range(0, 18000)) - 9000);
        v[16*$urandom_range(0, 2) +: 16] = ($urandom_range(0, 1)) ? 16'sd16384 - 16'($urandom_range(0, 3000))
                                                               : -16'sd16384 + 16'($urandom_range(0, 3000));
        return v;
    endfunction

    function automatic logic [47:0] rand_col();
        return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    endfunction

    task automatic send_beat(input shade_beat_t b);
        in_ch.valid           <= 1'b1;
        in_ch.light_dir       <= b.l;
        in_ch.surface_normal  <= b.n;
        in_ch.view_dir        <= b.v;
        in_ch.diffuse_coef    <= b.kd;
        in_ch.specular_coef   <= b.ks;
        in_ch.shininess       <= b.sh;
        in_ch.light_intensity <= b.li;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_colors.push_back(shade_color(b));
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // output side: random ready and checking
    always @(posedge clk)
    begin
        logic [47:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_colors.size() == 0)
            begin
                $display("unexpected output beat at %0t", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                if (fixed_colors.size() > 0)
                begin
                    if (fixed_valid.pop_front())
                        want = fixed_colors[0];
                    void'(fixed_colors.pop_front());
                end
                if (out_ch.red !== want[15:0])
                    report_mismatch("red", out_ch.red, want[15:0]);
                if (out_ch.green !== want[31:16])
                    report_mismatch("green", out_ch.green, want[31:16]);
                if (out_ch.blue !== want[47:32])
                    report_mismatch("blue", out_ch.blue, want[47:32]);
            end
        end
    end

    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            stall = sink_pause_on ? gap_len() : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // stimulus
    initial
    begin
        shade_row_t  rows[$];
        shade_beat_t b;
        int          wait_cnt;
        in_ch.valid = 1'b0;
        in_ch.light_dir = '0;
        in_ch.surface_normal = '0;
        in_ch.view_dir = '0;
        in_ch.diffuse_coef = '0;
        in_ch.specular_coef = '0;
        in_ch.shininess = '0;
        in_ch.light_intensity = '0;

        // directed table: l, n, v, kd, ks, li, sh, has_exp, exp
        // all-zero input gives black
        rows.push_back('{48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 8'd0, 1'b1, 48'h0});
        // zero exponent with zero r.v: specular power is one, intensity one
        rows.push_back('{48'h0, 48'h0, 48'h0, 48'h0, 48'hFFFF_FFFF_FFFF,
                         48'h8000_8000_8000, 8'd0, 1'b1, 48'hFFFF_FFFF_FFFF});
        // zero intensity always gives black
        rows.push_back('{48'h4000_0000_0000, 48'h4000_0000_0000, 48'h4000_0000_0000,
                         48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 8'd255,
                         1'b1, 48'h0});
        // everything along z, full colours: saturates
        rows.push_back('{48'h4000_0000_0000, 48'h4000_0000_0000, 48'h4000_0000_0000,
                         48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                         8'd1, 1'b1, 48'hFFFF_FFFF_FFFF});
        // light behind the surface, shininess nonzero
        rows.push_back('{48'hC000_0000_0000, 48'h4000_0000_0000, 48'h4000_0000_0000,
                         48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                         8'd7, 1'b0, 48'h0});
        // non-unit vectors, extreme components
        rows.push_back('{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                         48'h1234_5678_9ABC, 48'hFFFF_0000_8000, 48'h8000_FFFF_0001,
                         8'd255, 1'b0, 48'h0});
        rows.push_back('{48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                         48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                         8'd128, 1'b0, 48'h0});
        rows.push_back('{48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF, 48'hFFFF_0001_FFFF,
                         48'h0001_0001_0001, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                         8'd2, 1'b0, 48'h0});
        // oblique unit-ish vectors, each exponent bit alone
        for (int k = 0; k < 8; k++)
            rows.push_back('{48'h2D41_0000_2D41, 48'h4000_0000_0000, 48'h2D41_0000_D2BF,
                             48'h4000_6000_2000, 48'h8000_7000_FFFF, 48'hC000_8000_FFFF,
                             8'(1 << k), 1'b0, 48'h0});
        rows.push_back('{48'h3000_1000_2000, 48'h3800_0800_1000, 48'h3000_2000_0800,
                         48'h5555_AAAA_FFFF, 48'hAAAA_5555_0000, 48'h7FFF_FFFF_8000,
                         8'd33, 1'b0, 48'h0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (rows[i])
        begin
            b = '{rows[i].l, rows[i].n, rows[i].v, rows[i].kd, rows[i].ks, rows[i].li,
                  rows[i].sh};
            fixed_valid.push_back(rows[i].has_exp);
            fixed_colors.push_back(rows[i].exp_rgb);
            send_beat(b);
            idle_cycles(gap_len());
        end

        // random part
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            b.l  = rand_vec($urandom_range(0, 7) == 0);
            b.n  = rand_vec($urandom_range(0, 7) == 0);
            b.v  = rand_vec($urandom_range(0, 7) == 0);
            b.kd = rand_col();
            b.ks = rand_col();
            b.li = rand_col();
            b.sh = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
            send_beat(b);
            if ($urandom_range(0, 2) == 0)
                idle_cycles(gap_len());
            // hold off until the pipeline drains
            if (i == NUM_RANDOM / 2)
            begin
                in_ch.valid <= 1'b0;
                while (expected_colors.size() != 0)
                    @(posedge clk);
            end
            // a stretch with no stalls on the output
            if (i == NUM_RANDOM / 4)
                sink_pause_on = 1'b0;
            if (i == NUM_RANDOM / 4 + 100)
                sink_pause_on = 1'b1;
        end
        in_ch.valid <= 1'b0;

        wait_cnt = 0;
        while (expected_colors.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && expected_colors.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
